@@ rtl/fbsu_pkg.sv @@
// Package for the frame buffer scan-out unpacker: register indexes, pixel formats
// and the constant divide-by-three helper used for packed 24-bit pixels.
// No dependencies.
package fbsu_pkg;

	localparam int unsigned ADDR_W = 24;
	localparam int unsigned SIZE_W = 10;
	localparam int unsigned CFG_W  = 24;
	localparam int unsigned COORD_W = 11;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_START_EVEN  = 3'd0,
		REG_START_ODD   = 3'd1,
		REG_LINE_WORDS  = 3'd2,
		REG_LINES       = 3'd3,
		REG_LINE_GAP    = 3'd4,
		REG_FORMAT      = 3'd5,
		REG_CONCAT      = 3'd6,
		REG_INTERLACE   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FMT_RGB555   = 2'd0,
		FMT_RGB565   = 2'd1,
		FMT_RGB888   = 2'd2,
		FMT_XRGB8888 = 2'd3
	} pix_fmt_t;

	localparam logic [2:0] BPP_RESET = 3'd2;

	// Floor of x / 3 for x below 8192, by multiplying with 2731 / 8192.
	localparam logic [11:0] DIV3_RECIP = 12'd2731;

	function automatic logic [11:0] div3(input logic [12:0] x);
		logic [24:0] p;
		p = 25'(x) * 25'(DIV3_RECIP);
		return p[24:13];
	endfunction

endpackage

@@ rtl/framebuffer_scanout_unpack.sv @@
// Top level of the frame buffer scan-out unpacker: input stage, frame state,
// pixel expansion and the registered result word. Depends on fbsu_pkg.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | action, field_number, mem_word
//  output   | out_valid / out_stall  | read_addr, addr_valid, pixel_valid, chan_*,
//           |                        | out_row, out_column, line_last, frame_last,
//           |                        | frame_empty
//  config   | cfg_we (no handshake)  | cfg_index, cfg_data
//
// Every input word gives exactly one output word, after it has passed the input
// register and then the output register. One word is taken per cycle while the
// output is not stalled; the rate is set by the single 24-bit address add per word.
// Reset clears the configuration to its defaults and the frame state; no frame is
// active after reset. A stalled output holds its word while the input register
// still fills, so in_stall rises only when both registers are occupied.
module framebuffer_scanout_unpack
	import fbsu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic                 field_number,
	input  logic [31:0]          mem_word,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    read_addr,
	output logic                 addr_valid,
	output logic                 pixel_valid,
	output logic [7:0]           chan_low,
	output logic [7:0]           chan_mid,
	output logic [7:0]           chan_high,
	output logic [COORD_W-1:0]   out_row,
	output logic [COORD_W-1:0]   out_column,
	output logic                 line_last,
	output logic                 frame_last,
	output logic                 frame_empty,

	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [ADDR_W-1:0] start_even_q, start_odd_q;
	logic [SIZE_W-1:0] line_words_q, lines_q, line_gap_q;
	pix_fmt_t          format_q;
	logic [2:0]        concat_q;
	logic              interlace_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_even_q <= '0;
			start_odd_q  <= '0;
			line_words_q <= '0;
			lines_q      <= '0;
			line_gap_q   <= SIZE_W'(1);
			format_q     <= FMT_RGB555;
			concat_q     <= '0;
			interlace_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_EVEN: start_even_q <= cfg_data;
				REG_START_ODD:  start_odd_q  <= cfg_data;
				REG_LINE_WORDS: line_words_q <= cfg_data[SIZE_W-1:0];
				REG_LINES:      lines_q      <= cfg_data[SIZE_W-1:0];
				REG_LINE_GAP:   line_gap_q   <= cfg_data[SIZE_W-1:0];
				REG_FORMAT:     format_q     <= pix_fmt_t'(cfg_data[1:0]);
				REG_CONCAT:     concat_q     <= cfg_data[2:0];
				REG_INTERLACE:  interlace_q  <= cfg_data[0];
			endcase
		end
	end

	// Input register stage.
	logic        valid_s1;
	logic        action_s1;
	logic        field_s1;
	logic [31:0] word_s1;
	logic        adv;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			field_s1  <= field_number;
			word_s1   <= mem_word;
		end
	end

	// Frame state. The line step holds the bytes per pixel plus the line gap, so
	// the end of a line costs one add like any other pixel.
	logic [ADDR_W-1:0]  addr_q;
	logic [COORD_W-1:0] column_q;
	logic [SIZE_W-1:0]  row_q;
	logic               active_q;
	logic               field_q;
	logic [11:0]        ppl_q;
	logic [ADDR_W-1:0]  line_step_q;
	logic [2:0]         bpp_q;
	pix_fmt_t           frame_fmt_q;
	logic [SIZE_W-1:0]  frame_lines_q;
	logic               frame_ilace_q;

	// Frame start arithmetic, from live configuration.
	logic              size_zero;
	logic [SIZE_W:0]   words_p1;
	logic [11:0]       w16;
	logic [ADDR_W-1:0] gap_m1;
	logic [ADDR_W-1:0] gap4;
	logic [11:0]       gap_third;
	logic [11:0]       start_ppl;
	logic [2:0]        start_bpp;
	logic [ADDR_W-1:0] start_gap;
	logic [ADDR_W-1:0] start_addr;

	always_comb begin
		size_zero = (line_words_q == '0) || (lines_q == '0);
		words_p1  = {1'b0, line_words_q} + (SIZE_W+1)'(1);
		w16       = {words_p1, 1'b0};
		gap_m1    = ADDR_W'(line_gap_q) - ADDR_W'(1);
		// Gap in bytes is four times (gap words - 1) for every format but packed
		// 24-bit, where the gap is rounded down to whole 3-byte pixels.
		gap4      = {gap_m1[ADDR_W-3:0], 2'b00};
		gap_third = div3(gap4[12:0]);
		unique case (format_q)
			FMT_RGB555, FMT_RGB565: begin
				start_bpp = 3'd2;
				start_ppl = w16;
				start_gap = gap4;
			end
			FMT_RGB888: begin
				start_bpp = 3'd3;
				start_ppl = div3({w16, 1'b0});
				// A zero gap register is a gap of minus one pixel.
				if (line_gap_q == '0) begin
					start_gap = ADDR_W'(0) - ADDR_W'(3);
				end else begin
					start_gap = ADDR_W'({gap_third, 1'b0}) + ADDR_W'(gap_third);
				end
			end
			FMT_XRGB8888: begin
				start_bpp = 3'd4;
				start_ppl = 12'(words_p1);
				start_gap = gap4;
			end
		endcase
		start_addr = (interlace_q && field_s1) ? start_odd_q : start_even_q;
	end

	// Pixel path.
	logic [15:0]        half;
	logic [7:0]         c_low, c_mid, c_high;
	logic               ll, fl;
	logic [ADDR_W-1:0]  addr_next;
	logic [COORD_W-1:0] row_out;

	always_comb begin
		half = word_s1[15:0];
		unique case (frame_fmt_q)
			FMT_RGB555: begin
				c_low  = {half[4:0], concat_q};
				c_mid  = {half[9:5], concat_q};
				c_high = {half[14:10], concat_q};
			end
			FMT_RGB565: begin
				c_low  = {half[4:0], concat_q};
				c_mid  = {half[10:5], concat_q[2:1]};
				c_high = {half[15:11], concat_q};
			end
			FMT_RGB888: begin
				// On an odd address the word was read one byte early.
				if (addr_q[0]) begin
					c_low  = word_s1[7:0];
					c_mid  = word_s1[15:8];
					c_high = word_s1[23:16];
				end else begin
					c_low  = word_s1[15:8];
					c_mid  = word_s1[23:16];
					c_high = word_s1[31:24];
				end
			end
			FMT_XRGB8888: begin
				c_low  = word_s1[7:0];
				c_mid  = word_s1[15:8];
				c_high = word_s1[23:16];
			end
		endcase
		ll        = (12'(column_q) + 12'd1) == ppl_q;
		fl        = ll && (row_q == frame_lines_q);
		addr_next = addr_q + (ll ? line_step_q : ADDR_W'(bpp_q));
		row_out   = frame_ilace_q ? {row_q, field_q} : COORD_W'(row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q        <= '0;
			column_q      <= '0;
			row_q         <= '0;
			active_q      <= 1'b0;
			field_q       <= 1'b0;
			ppl_q         <= '0;
			line_step_q   <= ADDR_W'(BPP_RESET);
			bpp_q         <= BPP_RESET;
			frame_fmt_q   <= FMT_RGB555;
			frame_lines_q <= '0;
			frame_ilace_q <= 1'b0;
		end else if (adv) begin
			if (!action_s1) begin
				if (size_zero) begin
					active_q <= 1'b0;
				end else begin
					addr_q        <= start_addr;
					column_q      <= '0;
					row_q         <= '0;
					active_q      <= 1'b1;
					field_q       <= field_s1;
					ppl_q         <= start_ppl;
					line_step_q   <= start_gap + ADDR_W'(start_bpp);
					bpp_q         <= start_bpp;
					frame_fmt_q   <= format_q;
					frame_lines_q <= lines_q;
					frame_ilace_q <= interlace_q;
				end
			end else if (active_q) begin
				addr_q <= addr_next;
				if (ll) begin
					column_q <= '0;
					row_q    <= row_q + SIZE_W'(1);
				end else begin
					column_q <= column_q + COORD_W'(1);
				end
				if (fl) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// Output register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_addr   <= '0;
			addr_valid  <= 1'b0;
			pixel_valid <= 1'b0;
			chan_low    <= '0;
			chan_mid    <= '0;
			chan_high   <= '0;
			out_row     <= '0;
			out_column  <= '0;
			line_last   <= 1'b0;
			frame_last  <= 1'b0;
			frame_empty <= 1'b0;
			if (!action_s1) begin
				if (size_zero) begin
					frame_empty <= 1'b1;
				end else begin
					read_addr  <= start_addr;
					addr_valid <= 1'b1;
				end
			end else if (active_q) begin
				pixel_valid <= 1'b1;
				chan_low    <= c_low;
				chan_mid    <= c_mid;
				chan_high   <= c_high;
				out_row     <= row_out;
				out_column  <= column_q;
				line_last   <= ll;
				frame_last  <= fl;
				if (!fl) begin
					read_addr  <= addr_next;
					addr_valid <= 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;

	// The input register only backs up behind a held output word.
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a held output word");

	// An empty frame result carries nothing else.
	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_empty) |-> (!addr_valid && !pixel_valid && read_addr == '0))
		else $error("empty frame result with other fields set");

	// The last pixel of a frame closes its line and asks for no further word.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (line_last && pixel_valid && !addr_valid))
		else $error("frame end marked inconsistently");

	// A frame is only ever closed by a word leaving the input register.
	a_active_falls: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> $past(adv))
		else $error("frame state changed with no word advancing");

	// A pixel inside a frame always names the next read address.
	a_pixel_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_valid && !frame_last) |-> addr_valid)
		else $error("pixel inside a frame without a next address");

endmodule

@@ dv/framebuffer_scanout_unpack_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the frame buffer scan-out unpacker: directed frames,
// then random frames under three idling mixes and a long output hold.
// Depends on fbsu_pkg and rtl/framebuffer_scanout_unpack.sv.
module framebuffer_scanout_unpack_tb;
	import fbsu_pkg::*;

	// Input word kinds. The package has no names for them, so they live here.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// Cycles with no word moving on either channel before the run is declared hung.
	// The longest legal quiet stretch is the long output hold below.
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 400;

	// One output word as the block should present it.
	typedef struct {
		logic [ADDR_W-1:0]  read_addr;
		logic               addr_valid;
		logic               pixel_valid;
		logic [7:0]         chan_low;
		logic [7:0]         chan_mid;
		logic [7:0]         chan_high;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic               line_last;
		logic               frame_last;
		logic               frame_empty;
	} scan_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               action = ACT_START;
	logic               field_number = 1'b0;
	logic [31:0]        mem_word = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [ADDR_W-1:0]  read_addr;
	logic               addr_valid;
	logic               pixel_valid;
	logic [7:0]         chan_low;
	logic [7:0]         chan_mid;
	logic [7:0]         chan_high;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_column;
	logic               line_last;
	logic               frame_last;
	logic               frame_empty;
	logic               cfg_we = 1'b0;
	cfg_reg_t           cfg_index = REG_START_EVEN;
	logic [CFG_W-1:0]   cfg_data = '0;

	framebuffer_scanout_unpack u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.field_number (field_number),
		.mem_word     (mem_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_addr    (read_addr),
		.addr_valid   (addr_valid),
		.pixel_valid  (pixel_valid),
		.chan_low     (chan_low),
		.chan_mid     (chan_mid),
		.chan_high    (chan_high),
		.out_row      (out_row),
		.out_column   (out_column),
		.line_last    (line_last),
		.frame_last   (frame_last),
		.frame_empty  (frame_empty),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Shadow copy of the configuration registers, with their reset values.
	logic [ADDR_W-1:0] sh_start_even = '0;
	logic [ADDR_W-1:0] sh_start_odd  = '0;
	logic [9:0]        sh_line_words = '0;
	logic [9:0]        sh_lines      = '0;
	logic [9:0]        sh_gap_words  = 10'd1;
	pix_fmt_t          sh_format     = FMT_RGB555;
	logic [2:0]        sh_concat     = '0;
	logic              sh_interlace  = 1'b0;

	// Frame state as the block should hold it. Format, line count, interlace and
	// field are latched when a frame starts; concat is read live on every pixel.
	logic [ADDR_W-1:0] fr_addr      = '0;
	logic [10:0]       fr_col       = '0;
	logic [9:0]        fr_row       = '0;
	logic              fr_active    = 1'b0;
	logic              fr_field     = 1'b0;
	logic [ADDR_W-1:0] fr_gap       = '0;
	int                fr_ppl       = 0;
	int                fr_bpp       = 2;
	int                fr_lines     = 0;
	pix_fmt_t          fr_format    = FMT_RGB555;
	logic              fr_interlace = 1'b0;

	// Output words still owed by the block, oldest first.
	scan_word_t pending_words[$];

	int errors = 0;
	int words_sent = 0;
	int n_starts = 0, n_empty = 0, n_pixels = 0, n_ignored = 0;
	int n_lines = 0, n_frames = 0, n_checked = 0;

	// Idling mix, set by the test tasks and read by the driver and the receiver.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;

	// A bump of hold_trigger asks the receiver for one long hold.
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int quiet_cycles = 0;

	// Works out the output word for one accepted input word and advances the
	// frame state. A pixel word with no frame running is ignored by the block
	// and gives an all-zero word; 'ignored' reports that case to the caller.
	task automatic predict_scanout(input logic act, input logic fld, input logic [31:0] w,
			output bit ignored);
		scan_word_t r;
		int w16, g16, gp, gap_total;
		logic [15:0] h;
		bit ll, fl;
		r = '{default: '0};
		ignored = 1'b0;
		h = w[15:0];
		if (act == ACT_START) begin
			n_starts++;
			if (sh_line_words == 0 || sh_lines == 0) begin
				// A zero size ends the frame at once, and any running frame with it.
				fr_active = 1'b0;
				r.frame_empty = 1'b1;
				n_empty++;
			end else begin
				// Line length and gap are given in 32-bit words; work in 16-bit
				// halves so that packed 24-bit pixels divide evenly where they can.
				w16 = (int'(sh_line_words) + 1) * 2;
				g16 = (int'(sh_gap_words) - 1) * 2;
				fr_format = sh_format;
				case (fr_format)
					FMT_RGB555, FMT_RGB565: begin
						fr_bpp = 2;
						fr_ppl = w16;
						gp = g16;
					end
					FMT_RGB888: begin
						fr_bpp = 3;
						fr_ppl = (w16 * 2) / 3;
						gp = (g16 * 2) / 3;
					end
					default: begin
						fr_bpp = 4;
						fr_ppl = w16 / 2;
						gp = g16 / 2;
					end
				endcase
				// A zero gap register gives a negative gap, which wraps the address.
				gap_total = gp * fr_bpp;
				fr_gap = gap_total[ADDR_W-1:0];
				fr_lines = int'(sh_lines) + 1;
				fr_interlace = sh_interlace;
				fr_field = fld;
				fr_addr = (fr_interlace && fld) ? sh_start_odd : sh_start_even;
				fr_col = '0;
				fr_row = '0;
				fr_active = 1'b1;
				r.read_addr = fr_addr;
				r.addr_valid = 1'b1;
			end
		end else if (!fr_active) begin
			ignored = 1'b1;
			n_ignored++;
		end else begin
			n_pixels++;
			case (fr_format)
				FMT_RGB555: begin
					r.chan_low  = {h[4:0], 3'b000} + {5'b0, sh_concat};
					r.chan_mid  = {h[9:5], 3'b000} + {5'b0, sh_concat};
					r.chan_high = {h[14:10], 3'b000} + {5'b0, sh_concat};
				end
				FMT_RGB565: begin
					r.chan_low  = {h[4:0], 3'b000} + {5'b0, sh_concat};
					r.chan_mid  = {h[10:5], 2'b00} + {6'b0, sh_concat[2:1]};
					r.chan_high = {h[15:11], 3'b000} + {5'b0, sh_concat};
				end
				FMT_RGB888: begin
					// An odd address means the word was read one byte lower, so
					// the pixel sits in the low three bytes.
					if (fr_addr[0]) begin
						r.chan_low  = w[7:0];
						r.chan_mid  = w[15:8];
						r.chan_high = w[23:16];
					end else begin
						r.chan_low  = w[15:8];
						r.chan_mid  = w[23:16];
						r.chan_high = w[31:24];
					end
				end
				default: begin
					r.chan_low  = w[7:0];
					r.chan_mid  = w[15:8];
					r.chan_high = w[23:16];
				end
			endcase
			ll = (int'(fr_col) + 1 == fr_ppl);
			fl = ll && (int'(fr_row) + 1 == fr_lines);
			r.pixel_valid = 1'b1;
			r.row = fr_interlace ? {fr_row, fr_field} : {1'b0, fr_row};
			r.column = fr_col;
			r.line_last = ll;
			r.frame_last = fl;
			fr_addr = fr_addr + ADDR_W'(fr_bpp);
			if (ll) begin
				fr_addr = fr_addr + fr_gap;
				fr_col = '0;
				fr_row = fr_row + 10'd1;
				n_lines++;
			end else begin
				fr_col = fr_col + 11'd1;
			end
			if (fl) begin
				fr_active = 1'b0;
				n_frames++;
			end else begin
				r.read_addr = fr_addr;
				r.addr_valid = 1'b1;
			end
		end
		pending_words = {pending_words, r};
	endtask

	// Offers one input word, idling first by the current mix, and waits until
	// the block takes it. Valid stays high afterwards so that back-to-back words
	// need no second assignment in one step; drain_results lowers it.
	task automatic send_word(input logic act, input logic fld, input logic [31:0] w);
		bit ignored;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		field_number <= fld;
		mem_word <= w;
		do @(posedge clk); while (in_stall);
		predict_scanout(act, fld, w, ignored);
		if (!ignored)
			words_sent++;
	endtask

	// Stops offering and waits until every owed output word has been taken, so
	// that the block is idle and may be reconfigured.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// One register write, then a wait with cfg_we low so that writes never overlap.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START_EVEN: sh_start_even = val[ADDR_W-1:0];
			REG_START_ODD:  sh_start_odd = val[ADDR_W-1:0];
			REG_LINE_WORDS: sh_line_words = val[9:0];
			REG_LINES:      sh_lines = val[9:0];
			REG_LINE_GAP:   sh_gap_words = val[9:0];
			REG_FORMAT:     sh_format = pix_fmt_t'(val[1:0]);
			REG_CONCAT:     sh_concat = val[2:0];
			default:        sh_interlace = val[0];
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [ADDR_W-1:0] even, input logic [ADDR_W-1:0] odd,
			input logic [9:0] line_words, input logic [9:0] lines, input logic [9:0] gap,
			input pix_fmt_t fmt, input logic [2:0] cc, input logic il);
		write_reg(REG_START_EVEN, even);
		write_reg(REG_START_ODD, odd);
		write_reg(REG_LINE_WORDS, CFG_W'(line_words));
		write_reg(REG_LINES, CFG_W'(lines));
		write_reg(REG_LINE_GAP, CFG_W'(gap));
		write_reg(REG_FORMAT, CFG_W'(fmt));
		write_reg(REG_CONCAT, CFG_W'(cc));
		write_reg(REG_INTERLACE, CFG_W'(il));
	endtask

	// Start addresses lean toward both ends so that the 24-bit wrap is hit.
	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(3))
			0:       return '0;
			1:       return 24'hFFFFFF - 24'($urandom_range(40));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_mem_word();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// One frame: a start word, then pixels until the frame ends. Now and then the
	// frame is cut short so that the next start abandons it, concat is changed
	// mid-frame, or a stray pixel word follows.
	task automatic run_frame();
		int cut;
		send_word(ACT_START, 1'($urandom_range(1)), $urandom);
		cut = ($urandom_range(7) == 0) ? int'($urandom_range(6)) : -1;
		while (fr_active && cut != 0) begin
			if ($urandom_range(39) == 0) begin
				drain_results();
				write_reg(REG_CONCAT, CFG_W'($urandom_range(7)));
			end
			send_word(ACT_PIXEL, 1'($urandom_range(1)), pick_mem_word());
			if (cut > 0)
				cut--;
		end
		if ($urandom_range(4) == 0)
			send_word(ACT_PIXEL, 1'($urandom_range(1)), pick_mem_word());
	endtask

	// Random frames with small sizes; each size register is zero in a tenth of the settings.
	task automatic test_random_frames(input int unsigned tx_pct, input int unsigned rx_pct,
			input int count);
		int goal;
		logic [9:0] lw, ln, gap;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		goal = words_sent + count;
		while (words_sent < goal) begin
			drain_results();
			lw = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 3));
			ln = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 3));
			case ($urandom_range(7))
				0:       gap = 10'd0;
				1:       gap = 10'd1;
				2:       gap = 10'd1023;
				default: gap = 10'($urandom_range(1023));
			endcase
			configure(pick_addr(), pick_addr(), lw, ln, gap, pix_fmt_t'($urandom_range(3)),
				3'($urandom_range(7)), 1'($urandom_range(1)));
			repeat ($urandom_range(2, 4))
				run_frame();
		end
		drain_results();
	endtask

	// Straight after reset: a stray pixel is ignored and the default sizes of
	// zero give an empty frame.
	task automatic test_after_reset();
		send_word(ACT_PIXEL, 1'b1, 32'hFFFF_FFFF);
		send_word(ACT_START, 1'b0, 32'h0);
		drain_results();
	endtask

	// Interlaced 565, odd field, starting two bytes below the top of the address
	// space with a zero gap register, so that the address wraps. Concat changes
	// during the second line and a stray pixel follows the frame end.
	task automatic test_interlaced_565();
		configure(24'h000010, 24'hFFFFFE, 10'd1, 10'd1, 10'd0, FMT_RGB565, 3'd7, 1'b1);
		send_word(ACT_START, 1'b1, 32'h0);
		send_word(ACT_PIXEL, 1'b0, 32'hFFFF_FFFF);
		send_word(ACT_PIXEL, 1'b1, 32'h0000_0000);
		send_word(ACT_PIXEL, 1'b0, 32'h5A5A_A5A5);
		send_word(ACT_PIXEL, 1'b1, $urandom);
		send_word(ACT_PIXEL, 1'b0, $urandom);
		drain_results();
		write_reg(REG_CONCAT, CFG_W'(3'd3));
		while (fr_active)
			send_word(ACT_PIXEL, 1'b1, pick_mem_word());
		send_word(ACT_PIXEL, 1'b0, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// Packed 888 from an odd address, abandoned by a restart in 0888 with the
	// largest sizes; then a zero line count empties the frame and the next pixel
	// is ignored.
	task automatic test_packed_restart();
		configure(24'h000001, 24'h123456, 10'd2, 10'd1, 10'd1023, FMT_RGB888, 3'd5, 1'b1);
		send_word(ACT_START, 1'b0, 32'hFFFF_FFFF);
		send_word(ACT_PIXEL, 1'b0, 32'hFFFF_FFFF);
		send_word(ACT_PIXEL, 1'b1, 32'h1234_5678);
		send_word(ACT_PIXEL, 1'b0, 32'h0);
		drain_results();
		configure(24'hFFFFFF, 24'h000000, 10'd1023, 10'd1023, 10'd1, FMT_XRGB8888, 3'd0,
			1'b0);
		send_word(ACT_START, 1'b1, 32'h0);
		send_word(ACT_PIXEL, 1'b1, 32'hFFFF_FFFF);
		send_word(ACT_PIXEL, 1'b0, 32'h0);
		send_word(ACT_PIXEL, 1'b1, $urandom);
		drain_results();
		write_reg(REG_LINES, CFG_W'(10'd0));
		send_word(ACT_START, 1'b0, 32'h0);
		send_word(ACT_PIXEL, 1'b1, 32'hA5A5_5A5A);
		drain_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// pixels of a 555 frame, so both pipeline registers fill and in_stall rises.
	task automatic test_long_hold();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		configure(24'h000100, 24'h000200, 10'd7, 10'd3, 10'd2, FMT_RGB555, 3'd1, 1'b0);
		send_word(ACT_START, 1'b0, 32'h0);
		hold_trigger++;
		repeat (48)
			send_word(ACT_PIXEL, 1'($urandom_range(1)), $urandom);
		drain_results();
	endtask

	// Receiver: a long hold when one is asked for, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Every output word taken is compared with the oldest owed word.
	always @(posedge clk) begin
		scan_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("output word with nothing owed: read_addr 0x%0h", read_addr);
				errors++;
			end else begin
				want = pending_words.pop_front();
				n_checked++;
				check_field("read_addr", want.read_addr, read_addr);
				check_field("addr_valid", want.addr_valid, addr_valid);
				check_field("pixel_valid", want.pixel_valid, pixel_valid);
				check_field("chan_low", want.chan_low, chan_low);
				check_field("chan_mid", want.chan_mid, chan_mid);
				check_field("chan_high", want.chan_high, chan_high);
				check_field("out_row", want.row, out_row);
				check_field("out_column", want.column, out_column);
				check_field("line_last", want.line_last, line_last);
				check_field("frame_last", want.frame_last, frame_last);
				check_field("frame_empty", want.frame_empty, frame_empty);
			end
		end
	end

	// Hang detector: too long with no word moving on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_interlaced_565();
		test_packed_restart();
		test_random_frames(35, 81, 460);
		test_random_frames(81, 35, 460);
		test_random_frames(0, 0, 460);
		test_long_hold();

		// All stimulus is in and drained; keep the clock running so that any stray
		// output word would show.
		repeat (8) @(posedge clk);

		$display("Frames: %0d starts, %0d empty, %0d ran to the end; %0d lines ended.",
			n_starts, n_empty, n_frames, n_lines);
		$display("Words: %0d pixels, %0d ignored pixels, %0d output words checked.",
			n_pixels, n_ignored, n_checked);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
